>>> rtl/cgdc_pkg.sv
// Shared types and constants for the color guided drive controller.
// No dependencies; every other rtl file refers to it by scoped names.
package cgdc_pkg;

    localparam int MAX_TURN_TICKS_DEF = 200;

    localparam int FULL_TURN    = 5760;
    localparam int HALF_TURN    = 2880;
    localparam int QUARTER_TURN = 1440;

    localparam logic [0:0]  PRESENT_RST = 1'b0;
    localparam logic [7:0]  CRUISE_RST  = 8'd180;
    localparam logic [7:0]  LIMIT_RST   = 8'd140;
    localparam logic [7:0]  STEP_RST    = 8'd10;
    localparam logic [7:0]  GAIN_RST    = 8'd24;
    localparam logic [11:0] TOL_RST     = 12'd32;
    localparam logic [15:0] DARK_RST    = 16'd10;
    localparam logic [31:0] THRESH_RST  = 32'h7340_6640;

    typedef enum logic [2:0] {
        REG_PRESENT = 3'd0,
        REG_CRUISE  = 3'd1,
        REG_LIMIT   = 3'd2,
        REG_STEP    = 3'd3,
        REG_GAIN    = 3'd4,
        REG_TOL     = 3'd5,
        REG_DARK    = 3'd6,
        REG_THRESH  = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_DARK      = 3'd0,
        ST_RED_STOP  = 3'd1,
        ST_ADVANCE   = 3'd2,
        ST_TURNING   = 3'd3,
        ST_REACHED   = 3'd4,
        ST_TIMEOUT   = 3'd5,
        ST_NO_SENSOR = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        COLOR_DARK  = 2'd0,
        COLOR_RED   = 2'd1,
        COLOR_GREEN = 2'd2,
        COLOR_OTHER = 2'd3
    } color_t;

    typedef struct packed {
        color_t      color;
        logic [12:0] goal;
    } cls_t;

    typedef struct packed {
        logic signed [8:0] drive;
        status_t           status;
        logic              active;
        logic [7:0]        ticks;
    } turn_t;

endpackage

>>> rtl/cgdc_classify.sv
// Color classification of one tick by Q8 cross-multiplied ratio tests,
// plus the candidate heading goal yaw + 90 degrees. Uses cgdc_pkg.
module cgdc_classify (
    input  logic [12:0]        yaw,
    input  logic [15:0]        red_count,
    input  logic [15:0]        green_count,
    input  logic [15:0]        clear_count,
    input  logic [15:0]        dark_limit,
    input  logic [31:0]        thresholds,
    output cgdc_pkg::cls_t     cls
);

    logic [23:0] r8, g8;
    logic [23:0] red_hi_p, grn_lo_p, grn_hi_p, red_lo_p;
    logic        is_red, is_green;
    logic [13:0] goal_sum;

    assign r8 = {red_count, 8'd0};
    assign g8 = {green_count, 8'd0};

    assign red_hi_p = 24'(thresholds[31:24]) * 24'(clear_count);
    assign grn_lo_p = 24'(thresholds[23:16]) * 24'(clear_count);
    assign grn_hi_p = 24'(thresholds[15:8])  * 24'(clear_count);
    assign red_lo_p = 24'(thresholds[7:0])   * 24'(clear_count);

    assign is_red   = (r8 > red_hi_p) && (g8 < grn_lo_p);
    assign is_green = (g8 > grn_hi_p) && (r8 < red_lo_p);

    assign goal_sum = 14'(yaw) + 14'(cgdc_pkg::QUARTER_TURN);

    always_comb begin
        if (clear_count <= dark_limit) begin
            cls.color = cgdc_pkg::COLOR_DARK;
        end else if (is_red) begin
            cls.color = cgdc_pkg::COLOR_RED;
        end else if (is_green) begin
            cls.color = cgdc_pkg::COLOR_GREEN;
        end else begin
            cls.color = cgdc_pkg::COLOR_OTHER;
        end
        if (goal_sum >= 14'(cgdc_pkg::FULL_TURN)) begin
            cls.goal = 13'(goal_sum - 14'(cgdc_pkg::FULL_TURN));
        end else begin
            cls.goal = goal_sum[12:0];
        end
    end

endmodule

>>> rtl/cgdc_turn.sv
// One proportional turn step: wrapped heading error, tolerance and
// timeout checks, clamped drive. Uses cgdc_pkg.
module cgdc_turn #(
    parameter int MAX_TURN_TICKS = cgdc_pkg::MAX_TURN_TICKS_DEF
) (
    input  logic [12:0]     target,
    input  logic [12:0]     yaw,
    input  logic [7:0]      ticks,
    input  logic [7:0]      gain,
    input  logic [11:0]     tolerance,
    input  logic [7:0]      limit,
    output cgdc_pkg::turn_t res
);

    logic signed [14:0] err0, err;
    logic        [14:0] mag_w;
    logic        [11:0] mag;
    logic        [19:0] prod;
    logic        [11:0] scaled;
    logic        [7:0]  clamped;
    logic signed [8:0]  drive_pos;

    assign err0 = $signed({2'b00, target}) - $signed({2'b00, yaw});

    always_comb begin
        if (err0 > 15'sd2880) begin
            err = err0 - 15'sd5760;
        end else if (err0 < -15'sd2880) begin
            err = err0 + 15'sd5760;
        end else begin
            err = err0;
        end
    end

    assign mag_w     = err[14] ? 15'(-err) : 15'(err);
    assign mag       = mag_w[11:0];
    assign prod      = 20'(mag) * 20'(gain);
    assign scaled    = prod[19:8];
    assign clamped   = (scaled > 12'(limit)) ? limit : scaled[7:0];
    assign drive_pos = $signed({1'b0, clamped});

    always_comb begin
        if (ticks >= 8'(MAX_TURN_TICKS)) begin
            res.drive  = '0;
            res.status = cgdc_pkg::ST_TIMEOUT;
            res.active = 1'b0;
            res.ticks  = ticks;
        end else if (mag < tolerance) begin
            res.drive  = '0;
            res.status = cgdc_pkg::ST_REACHED;
            res.active = 1'b0;
            res.ticks  = ticks;
        end else begin
            res.drive  = err[14] ? -drive_pos : drive_pos;
            res.status = cgdc_pkg::ST_TURNING;
            res.active = 1'b1;
            res.ticks  = ticks + 8'd1;
        end
    end

endmodule

>>> rtl/color_guided_drive_controller.sv
// Top level of the color guided drive controller: config registers,
// input stage, state update and result register. Uses cgdc_pkg,
// cgdc_classify and cgdc_turn.
//
// Usage:
//   s_* channel: one control tick per item (yaw, red/green/clear counts).
//   m_* channel: one result item per tick (left/right drive, status,
//   heading goal), in order.
//   cfg_* channel: register index and data; always ready, write only
//   while no item is in flight.
// Timing: the input stage register loads on the input accept edge and the result
//   register loads from it once empty or taken. Throughput: one item per cycle
//   while m_ready is high; the color test sits before the input stage register,
//   the turn step and ramp between it and the result register.
// Reset: aresetn low clears pipeline valids and drive state (not turning,
//   goal 0, ramp level 0) and loads register defaults; sensors read as
//   absent until register 0 is written.
// Stall: while m_ready is low the result holds; one more item is taken
//   into the input stage, then s_ready drops until the result is taken.
module color_guided_drive_controller #(
    parameter int MAX_TURN_TICKS = cgdc_pkg::MAX_TURN_TICKS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [12:0]        s_yaw,
    input  logic [15:0]        s_red_count,
    input  logic [15:0]        s_green_count,
    input  logic [15:0]        s_clear_count,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [8:0]  m_left_drive,
    output logic signed [8:0]  m_right_drive,
    output logic [2:0]         m_status,
    output logic [12:0]        m_heading_goal,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic        present_reg;
    logic [7:0]  cruise_reg, limit_reg, step_reg, gain_reg;
    logic [11:0] tol_reg;
    logic [15:0] dark_reg;
    logic [31:0] thresh_reg;

    logic        turning_reg, turning_next;
    logic [12:0] target_reg, target_next;
    logic [7:0]  ticks_reg, ticks_next;
    logic [7:0]  ramp_reg, ramp_next;

    logic           in_valid_reg;
    logic [12:0]    in_yaw_reg;
    cgdc_pkg::cls_t in_cls_reg;
    cgdc_pkg::cls_t cls;

    logic              out_valid_reg;
    logic signed [8:0] left_reg, left_next;
    logic signed [8:0] right_reg, right_next;
    cgdc_pkg::status_t status_reg, status_next;

    logic            advance;
    logic            start_turn;
    logic [12:0]     turn_target;
    logic [7:0]      turn_ticks_in;
    cgdc_pkg::turn_t turn_res;
    logic [8:0]      ramp_up, cruise_plus;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= cgdc_pkg::PRESENT_RST;
            cruise_reg  <= cgdc_pkg::CRUISE_RST;
            limit_reg   <= cgdc_pkg::LIMIT_RST;
            step_reg    <= cgdc_pkg::STEP_RST;
            gain_reg    <= cgdc_pkg::GAIN_RST;
            tol_reg     <= cgdc_pkg::TOL_RST;
            dark_reg    <= cgdc_pkg::DARK_RST;
            thresh_reg  <= cgdc_pkg::THRESH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cgdc_pkg::cfg_index_t'(cfg_index))
                cgdc_pkg::REG_PRESENT: present_reg <= cfg_data[0];
                cgdc_pkg::REG_CRUISE:  cruise_reg  <= cfg_data[7:0];
                cgdc_pkg::REG_LIMIT:   limit_reg   <= cfg_data[7:0];
                cgdc_pkg::REG_STEP:    step_reg    <= cfg_data[7:0];
                cgdc_pkg::REG_GAIN:    gain_reg    <= cfg_data[7:0];
                cgdc_pkg::REG_TOL:     tol_reg     <= cfg_data[11:0];
                cgdc_pkg::REG_DARK:    dark_reg    <= cfg_data[15:0];
                cgdc_pkg::REG_THRESH:  thresh_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    cgdc_classify u_classify (
        .yaw         (s_yaw),
        .red_count   (s_red_count),
        .green_count (s_green_count),
        .clear_count (s_clear_count),
        .dark_limit  (dark_reg),
        .thresholds  (thresh_reg),
        .cls         (cls)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_yaw_reg <= s_yaw;
            in_cls_reg <= cls;
        end
    end

    assign start_turn    = !turning_reg && (in_cls_reg.color == cgdc_pkg::COLOR_GREEN);
    assign turn_target   = start_turn ? in_cls_reg.goal : target_reg;
    assign turn_ticks_in = start_turn ? 8'd0 : ticks_reg;

    cgdc_turn #(
        .MAX_TURN_TICKS (MAX_TURN_TICKS)
    ) u_turn (
        .target    (turn_target),
        .yaw       (in_yaw_reg),
        .ticks     (turn_ticks_in),
        .gain      (gain_reg),
        .tolerance (tol_reg),
        .limit     (limit_reg),
        .res       (turn_res)
    );

    assign ramp_up     = 9'(ramp_reg) + 9'(step_reg);
    assign cruise_plus = 9'(cruise_reg) + 9'(step_reg);

    always_comb begin
        turning_next = turning_reg;
        target_next  = target_reg;
        ticks_next   = ticks_reg;
        ramp_next    = ramp_reg;
        left_next    = '0;
        right_next   = '0;
        status_next  = cgdc_pkg::ST_DARK;
        if (!present_reg) begin
            turning_next = 1'b0;
            status_next  = cgdc_pkg::ST_NO_SENSOR;
        end else if (turning_reg || start_turn) begin
            turning_next = turn_res.active;
            target_next  = turn_target;
            ticks_next   = turn_res.ticks;
            left_next    = turn_res.drive;
            right_next   = -turn_res.drive;
            status_next  = turn_res.status;
        end else begin
            case (in_cls_reg.color)
                cgdc_pkg::COLOR_DARK: status_next = cgdc_pkg::ST_DARK;
                cgdc_pkg::COLOR_RED:  status_next = cgdc_pkg::ST_RED_STOP;
                default: begin
                    if (ramp_reg < cruise_reg) begin
                        ramp_next = (ramp_up > 9'(cruise_reg)) ? cruise_reg : ramp_up[7:0];
                    end else if (ramp_reg > cruise_reg) begin
                        ramp_next = (9'(ramp_reg) >= cruise_plus) ? ramp_reg - step_reg
                                                                  : cruise_reg;
                    end
                    left_next   = $signed({1'b0, ramp_next});
                    right_next  = $signed({1'b0, ramp_next});
                    status_next = cgdc_pkg::ST_ADVANCE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turning_reg   <= 1'b0;
            target_reg    <= '0;
            ticks_reg     <= '0;
            ramp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                turning_reg   <= turning_next;
                target_reg    <= target_next;
                ticks_reg     <= ticks_next;
                ramp_reg      <= ramp_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            status_reg <= status_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_left_drive   = left_reg;
    assign m_right_drive  = right_reg;
    assign m_status       = status_reg;
    assign m_heading_goal = target_reg;

`ifndef NO_ASSERTIONS
    a_ticks_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ticks_reg <= 8'(MAX_TURN_TICKS))
        else $error("turn tick count beyond limit");

    a_goal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        target_reg < 13'(cgdc_pkg::FULL_TURN))
        else $error("heading goal out of range");

    a_turn_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == cgdc_pkg::ST_TURNING) |-> m_left_drive == -m_right_drive)
        else $error("turn drives not mirrored");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != cgdc_pkg::ST_TURNING) && (m_status != cgdc_pkg::ST_ADVANCE)
        |-> (m_left_drive == 9'sd0) && (m_right_drive == 9'sd0))
        else $error("nonzero drive on a stop status");

    a_no_sensor_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !present_reg |=> !turning_reg)
        else $error("turn kept without sensors");
`endif

endmodule

>>> tb/color_guided_drive_controller_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for color_guided_drive_controller: random and directed control ticks,
// several register settings, a scoreboard class that predicts every result item in order.
// Depends on cgdc_pkg and the rtl top module.

module color_guided_drive_controller_test;

    localparam int TURN_TICK_MAX = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;

    typedef struct {
        logic signed [8:0] left;
        logic signed [8:0] right;
        logic [2:0]        status;
        logic [12:0]       goal;
    } drive_result_t;

    class drive_scoreboard;
        logic        present;
        logic [7:0]  cruise;
        logic [7:0]  turn_limit;
        logic [7:0]  ramp_step;
        logic [7:0]  gain;
        logic [11:0] tolerance;
        logic [15:0] dark_limit;
        logic [31:0] thresholds;
        logic        turning;
        logic [12:0] goal;
        logic [7:0]  turn_ticks;
        logic [7:0]  ramp_level;
        drive_result_t expected_drives[$];
        int errors;
        int reports;
        int status_seen[7];

        function new();
            present    = cgdc_pkg::PRESENT_RST;
            cruise     = cgdc_pkg::CRUISE_RST;
            turn_limit = cgdc_pkg::LIMIT_RST;
            ramp_step  = cgdc_pkg::STEP_RST;
            gain       = cgdc_pkg::GAIN_RST;
            tolerance  = cgdc_pkg::TOL_RST;
            dark_limit = cgdc_pkg::DARK_RST;
            thresholds = cgdc_pkg::THRESH_RST;
            turning    = 1'b0;
            goal       = '0;
            turn_ticks = '0;
            ramp_level = '0;
            errors     = 0;
            reports    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void write_reg(cgdc_pkg::cfg_index_t idx, logic [31:0] data);
            unique case (idx)
                cgdc_pkg::REG_PRESENT: present    = data[0];
                cgdc_pkg::REG_CRUISE:  cruise     = data[7:0];
                cgdc_pkg::REG_LIMIT:   turn_limit = data[7:0];
                cgdc_pkg::REG_STEP:    ramp_step  = data[7:0];
                cgdc_pkg::REG_GAIN:    gain       = data[7:0];
                cgdc_pkg::REG_TOL:     tolerance  = data[11:0];
                cgdc_pkg::REG_DARK:    dark_limit = data[15:0];
                cgdc_pkg::REG_THRESH:  thresholds = data;
                default: ;
            endcase
        endfunction

        // one proportional step toward the goal heading, with timeout and tolerance checks
        function drive_result_t turn_once(logic [12:0] yaw);
            drive_result_t res;
            int e;
            int mag;
            int drv;
            res.left   = '0;
            res.right  = '0;
            res.goal   = goal;
            if (turn_ticks >= TURN_TICK_MAX) begin
                turning    = 1'b0;
                res.status = cgdc_pkg::ST_TIMEOUT;
                return res;
            end
            e = int'(goal) - int'(yaw);
            while (e > cgdc_pkg::HALF_TURN) e -= cgdc_pkg::FULL_TURN;
            while (e < -cgdc_pkg::HALF_TURN) e += cgdc_pkg::FULL_TURN;
            mag = (e < 0) ? -e : e;
            if (mag < int'(tolerance)) begin
                turning    = 1'b0;
                res.status = cgdc_pkg::ST_REACHED;
                return res;
            end
            drv = (mag * int'(gain)) >> 8;
            if (drv > int'(turn_limit)) drv = int'(turn_limit);
            if (e < 0) drv = -drv;
            turn_ticks = turn_ticks + 8'd1;
            res.left   = 9'(drv);
            res.right  = 9'(-drv);
            res.status = cgdc_pkg::ST_TURNING;
            return res;
        endfunction

        function void note_tick(logic [12:0] yaw, logic [15:0] rc, logic [15:0] gc,
                                logic [15:0] cc);
            drive_result_t res;
            int unsigned r8;
            int unsigned g8;
            int unsigned c;
            int lvl;
            r8 = {8'h00, rc, 8'h00};
            g8 = {8'h00, gc, 8'h00};
            c  = cc;
            res.left   = '0;
            res.right  = '0;
            res.status = cgdc_pkg::ST_DARK;
            if (!present) begin
                turning    = 1'b0;
                res.status = cgdc_pkg::ST_NO_SENSOR;
            end else if (turning) begin
                res = turn_once(yaw);
            end else if (cc <= dark_limit) begin
                res.status = cgdc_pkg::ST_DARK;
            end else if (r8 > thresholds[31:24] * c && g8 < thresholds[23:16] * c) begin
                res.status = cgdc_pkg::ST_RED_STOP;
            end else if (g8 > thresholds[15:8] * c && r8 < thresholds[7:0] * c) begin
                goal       = 13'((int'(yaw) + cgdc_pkg::QUARTER_TURN) % cgdc_pkg::FULL_TURN);
                turning    = 1'b1;
                turn_ticks = '0;
                res = turn_once(yaw);
            end else begin
                lvl = int'(ramp_level);
                if (lvl < int'(cruise)) begin
                    lvl += int'(ramp_step);
                    if (lvl > int'(cruise)) lvl = int'(cruise);
                end else if (lvl > int'(cruise)) begin
                    if (lvl >= int'(cruise) + int'(ramp_step)) lvl -= int'(ramp_step);
                    else lvl = int'(cruise);
                end
                ramp_level = 8'(lvl);
                res.left   = {1'b0, ramp_level};
                res.right  = {1'b0, ramp_level};
                res.status = cgdc_pkg::ST_ADVANCE;
            end
            res.goal = goal;
            expected_drives.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                if (reports < 50) begin
                    reports++;
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                end
            end
        endfunction

        function void check_drive(logic signed [8:0] left, logic signed [8:0] right,
                                  logic [2:0] status, logic [12:0] goal_out);
            drive_result_t want;
            if (expected_drives.size() == 0) begin
                errors++;
                if (reports < 50) begin
                    reports++;
                    $display("%0t: result item with no tick pending", $time);
                end
                return;
            end
            want = expected_drives.pop_front();
            status_seen[want.status]++;
            compare_field("left_drive", int'(want.left), int'(left));
            compare_field("right_drive", int'(want.right), int'(right));
            compare_field("status", int'(want.status), int'(status));
            compare_field("heading_goal", int'(want.goal), int'(goal_out));
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [12:0]       s_yaw         = '0;
    logic [15:0]       s_red_count   = '0;
    logic [15:0]       s_green_count = '0;
    logic [15:0]       s_clear_count = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic signed [8:0] m_left_drive;
    logic signed [8:0] m_right_drive;
    logic [2:0]        m_status;
    logic [12:0]       m_heading_goal;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index     = '0;
    logic [31:0]       cfg_data      = '0;

    drive_scoreboard sb;
    int send_idle_pct   = 29;
    int recv_idle_pct   = 59;
    int hold_token      = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int held_cycles     = 0;
    int heading_now     = 0;
    int ticks_sent      = 0;
    int settings_loaded = 0;

    color_guided_drive_controller #(
        .MAX_TURN_TICKS(TURN_TICK_MAX)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_yaw          (s_yaw),
        .s_red_count    (s_red_count),
        .s_green_count  (s_green_count),
        .s_clear_count  (s_clear_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_drive   (m_left_drive),
        .m_right_drive  (m_right_drive),
        .m_status       (m_status),
        .m_heading_goal (m_heading_goal),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    // result side: check accepted items, random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_drive(m_left_drive, m_right_drive, m_status, m_heading_goal);
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            held_cycles++;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_tick(input logic [12:0] yaw, input logic [15:0] rc,
                             input logic [15:0] gc, input logic [15:0] cc);
        s_valid       <= 1'b1;
        s_yaw         <= yaw;
        s_red_count   <= rc;
        s_green_count <= gc;
        s_clear_count <= cc;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(yaw, rc, gc, cc);
        ticks_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input cgdc_pkg::cfg_index_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic present, input logic [7:0] cruise,
                                 input logic [7:0] limit, input logic [7:0] step,
                                 input logic [7:0] gain, input logic [11:0] tol,
                                 input logic [15:0] dark, input logic [31:0] thr);
        quiesce();
        put_reg(cgdc_pkg::REG_PRESENT, {31'd0, present});
        put_reg(cgdc_pkg::REG_CRUISE, 32'(cruise));
        put_reg(cgdc_pkg::REG_LIMIT, 32'(limit));
        put_reg(cgdc_pkg::REG_STEP, 32'(step));
        put_reg(cgdc_pkg::REG_GAIN, 32'(gain));
        put_reg(cgdc_pkg::REG_TOL, 32'(tol));
        put_reg(cgdc_pkg::REG_DARK, 32'(dark));
        put_reg(cgdc_pkg::REG_THRESH, thr);
        settings_loaded++;
    endtask

    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic random_settings();
        load_settings(1'b1, 8'(pick(0, 255)), 8'(pick(0, 255)), 8'(pick(1, 255)),
                      8'(pick(0, 255)),
                      12'(($urandom_range(1) != 0) ? pick(0, 2880) : $urandom_range(96)),
                      16'(pick(0, 300)),
                      ($urandom_range(1) != 0) ? $urandom : cgdc_pkg::THRESH_RST);
    endtask

    // count as a Q8 fraction of clear, fraction drawn from lo..hi (256 = 1.0)
    function automatic logic [15:0] scaled(int unsigned cc, int unsigned lo, int unsigned hi);
        int unsigned v;
        if (hi < lo) hi = lo;
        v = (cc * $urandom_range(hi, lo)) >> 8;
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    // mostly well-formed color readings; yaw mostly follows the goal while a turn runs
    task automatic random_tick();
        int unsigned kind;
        int unsigned cc;
        int unsigned lo_cc;
        int err;
        int mag;
        int step;
        logic [12:0] yaw;
        logic [15:0] rc;
        logic [15:0] gc;
        kind  = $urandom_range(99);
        lo_cc = (sb.dark_limit == 16'hFFFF) ? 65535 : sb.dark_limit + 1;
        cc    = $urandom_range(65535, lo_cc);
        rc    = 16'($urandom);
        gc    = 16'($urandom);
        if (sb.turning && sb.present && $urandom_range(15) != 0) begin
            err = int'(sb.goal) - heading_now;
            while (err > cgdc_pkg::HALF_TURN) err -= cgdc_pkg::FULL_TURN;
            while (err < -cgdc_pkg::HALF_TURN) err += cgdc_pkg::FULL_TURN;
            mag  = (err < 0) ? -err : err;
            step = $urandom_range(400);
            if (step > mag) step = mag;
            heading_now = (heading_now + ((err < 0) ? -step : step) + cgdc_pkg::FULL_TURN)
                          % cgdc_pkg::FULL_TURN;
        end else if ($urandom_range(19) == 0) begin
            heading_now = $urandom_range(8191, 5760);
        end else begin
            heading_now = $urandom_range(5759);
        end
        yaw = 13'(heading_now);
        if (kind < 10) begin
            cc  = $urandom_range(65535);
            yaw = 13'($urandom);
        end else if (kind < 20) begin
            cc = $urandom_range(sb.dark_limit);
        end else if (kind < 40) begin
            rc = scaled(cc, sb.thresholds[31:24] + 1, 256);
            gc = scaled(cc, 0, sb.thresholds[23:16]);
        end else if (kind < 65) begin
            gc = scaled(cc, sb.thresholds[15:8] + 1, 256);
            rc = scaled(cc, 0, sb.thresholds[7:0]);
        end else begin
            rc = scaled(cc, 0, 256);
            gc = scaled(cc, 0, 256);
        end
        send_tick(yaw, rc, gc, 16'(cc));
    endtask

    initial begin : stimulus
        int n;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sensors absent out of reset
        send_tick(13'd0, 16'd0, 16'd0, 16'd0);
        send_tick(13'd8191, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        load_settings(1'b1, cgdc_pkg::CRUISE_RST, cgdc_pkg::LIMIT_RST, cgdc_pkg::STEP_RST,
                      cgdc_pkg::GAIN_RST, cgdc_pkg::TOL_RST, cgdc_pkg::DARK_RST,
                      cgdc_pkg::THRESH_RST);
        send_tick(13'd100, 16'd0, 16'd0, 16'd0);
        send_tick(13'd100, 16'd0, 16'd0, 16'd10);      // clear at the dark limit
        send_tick(13'd100, 16'd0, 16'd0, 16'd11);
        send_tick(13'd200, 16'hFFFF, 16'd0, 16'hFFFF);
        send_tick(13'd300, 16'd100, 16'd100, 16'd1000);
        send_tick(13'd0, 16'd0, 16'hFFFF, 16'hFFFF);   // green starts a turn
        send_tick(13'd700, 16'd0, 16'd0, 16'd0);
        send_tick(13'd1420, 16'd0, 16'd0, 16'd0);
        send_tick(13'd5759, 16'd0, 16'hFFFF, 16'hFFFF);
        send_tick(13'd8191, 16'd0, 16'd0, 16'd0);      // yaw past full circle
        send_tick(13'd5000, 16'd0, 16'd0, 16'd0);      // drive clamps at turn limit
        send_tick(13'd1450, 16'd0, 16'd0, 16'd0);
        send_tick(13'd4300, 16'd0, 16'hFFFF, 16'hFFFF);
        send_tick(13'd0, 16'd0, 16'd0, 16'd0);         // error wraps across zero
        send_tick(13'd6000, 16'd0, 16'hFFFF, 16'hFFFF);

        // sensors lost in the middle of a turn
        quiesce();
        put_reg(cgdc_pkg::REG_PRESENT, 32'd0);
        send_tick(13'd2000, 16'd0, 16'hFFFF, 16'hFFFF);
        quiesce();
        put_reg(cgdc_pkg::REG_PRESENT, 32'd1);
        put_reg(cgdc_pkg::REG_DARK, 32'h0000_FFFF);
        send_tick(13'd0, 16'd0, 16'd0, 16'hFFFF);
        quiesce();
        put_reg(cgdc_pkg::REG_DARK, 32'd10);
        send_tick(13'd10, 16'h1234, 16'h1234, 16'hFFFF);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 59;
                recv_idle_pct = 29;
            end
            if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: load_settings(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 12'd16, 16'd0,
                                 32'hFFFF_FFFF);
                2: load_settings(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 16'd0,
                                 cgdc_pkg::THRESH_RST);
                default: random_settings();
            endcase
            n = (phase == 2) ? 220 : 80;
            for (int i = 0; i < n; i++) begin
                if (phase == 4 && i == 20) hold_token <= hold_token + 1;
                random_tick();
            end
        end

        quiesce();
        repeat (8) @(posedge aclk);
        $display("Sent %0d ticks under %0d register settings, result side held off %0d cycles.",
                 ticks_sent, settings_loaded, held_cycles);
        $display("Statuses: dark %0d red %0d advance %0d turning %0d reached %0d timeout %0d %s %0d",
                 sb.status_seen[cgdc_pkg::ST_DARK], sb.status_seen[cgdc_pkg::ST_RED_STOP],
                 sb.status_seen[cgdc_pkg::ST_ADVANCE], sb.status_seen[cgdc_pkg::ST_TURNING],
                 sb.status_seen[cgdc_pkg::ST_REACHED], sb.status_seen[cgdc_pkg::ST_TIMEOUT],
                 "no-sensor", sb.status_seen[cgdc_pkg::ST_NO_SENSOR]);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
